### rtl/core/chse_pkg.sv
// ----------------------------------------------------------------------------
// chse_pkg
// Shared types, codes and defaults for the chained hash set engine.
// ----------------------------------------------------------------------------
package chse_pkg;

	localparam int NUM_BUCKETS_DEF = 16;
	localparam int CHAIN_DEPTH_DEF = 8;

	localparam logic [2:0] MODE_ADD       = 3'd0;
	localparam logic [2:0] MODE_DEL       = 3'd1;
	localparam logic [2:0] MODE_FIND      = 3'd2;
	localparam logic [2:0] MODE_GET_FIRST = 3'd3;
	localparam logic [2:0] MODE_GET_LAST  = 3'd4;
	localparam logic [2:0] MODE_DEL_FIRST = 3'd5;
	localparam logic [2:0] MODE_DEL_LAST  = 3'd6;

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_MISS = 3'd1;
	localparam logic [2:0] ST_DUP  = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_BAD  = 3'd4;

	localparam logic REG_HASH_KIND    = 1'b0;
	localparam logic REG_BUCKET_COUNT = 1'b1;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] key;
		logic [31:0]        value;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] found_value;
		logic [3:0]  bucket;
	} rsp_t;

	typedef struct packed {
		logic       load;
		logic       mul1;
		logic       mul2;
		logic       div_init;
		logic       div_step;
		logic       rd_idx;
		logic       cmp;
		logic       add_tail;
		logic       scan_init;
		logic       scan_step;
		logic       get_rd;
		logic       get_cap;
		logic       pos0;
		logic       rd_next;
		logic       wr_shift;
		logic       dec;
		logic       fin;
		logic       fin_bkt;
		logic [2:0] fin_st;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       bad_in;
		logic       is_char;
		logic       div_last;
		logic       idx_end;
		logic       match;
		logic       hit;
		logic       full;
		logic       scan_nz;
		logic       scan_end;
		logic       del_more;
	} sts_t;

endpackage

### rtl/core/chained_hash_set_engine.sv
// ----------------------------------------------------------------------------
// chained_hash_set_engine
// Bucketed hash set of 32-bit tags with ordered chains per bucket.
//
//  channel  handshake              payload
//  request  start & !busy          req  (mode, key, value)
//  result   done, one cycle        rsp  (status, found_value, bucket)
//  config   psel&penable&pwrite    paddr, pwdata / prdata
//
// Add, delete, find: hash (a multiply first in char mode; 32-step serial modulo),
// compare chain slots in order, finish; delete shifts later slots down. First/last
// ops: scan buckets in order, then read a tag, or shift slots down to delete first.
// done rises in the cycle after the finishing cycle. One transaction at a time;
// busy is high until the result strobe. Reset clears chain counts, config and FSM
// state, not the tag RAM. The receiver cannot stall: done lasts one cycle.
// ----------------------------------------------------------------------------
module chained_hash_set_engine #(
	parameter int NUM_BUCKETS = chse_pkg::NUM_BUCKETS_DEF,
	parameter int CHAIN_DEPTH = chse_pkg::CHAIN_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  chse_pkg::req_t req,
	output logic           done,
	output chse_pkg::rsp_t rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	localparam int DEPTH = NUM_BUCKETS * CHAIN_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic       hash_kind_q;
	logic [4:0] bucket_count_q;

	chse_pkg::cmd_t cmd;
	chse_pkg::sts_t sts;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_kind_q    <= 1'b0;
			bucket_count_q <= 5'd16;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == chse_pkg::REG_HASH_KIND) begin
				hash_kind_q <= pwdata[0];
			end else begin
				bucket_count_q <= pwdata[4:0];
			end
		end
	end

	assign prdata = (paddr[2] == chse_pkg::REG_BUCKET_COUNT) ?
	                {27'd0, bucket_count_q} : {31'd0, hash_kind_q};

	chse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	chse_dp #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.CHAIN_DEPTH (CHAIN_DEPTH),
		.AW          (AW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req          (req),
		.hash_kind    (hash_kind_q),
		.bucket_count (bucket_count_q),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.done         (done),
		.rsp          (rsp)
	);

	chse_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

### rtl/core/chse_ram.sv
// ----------------------------------------------------------------------------
// chse_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module chse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/chse_ctrl.sv
// ----------------------------------------------------------------------------
// chse_ctrl
// Operation sequencer: hash, chain search, bucket scan and chain compaction.
// ----------------------------------------------------------------------------
module chse_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  chse_pkg::sts_t sts,
	output chse_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_MUL2 = 4'd2;
	localparam logic [3:0] S_DINI = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_SCHK = 4'd5;
	localparam logic [3:0] S_SCMP = 4'd6;
	localparam logic [3:0] S_POST = 4'd7;
	localparam logic [3:0] S_SCAN = 4'd8;
	localparam logic [3:0] S_GWT  = 4'd9;
	localparam logic [3:0] S_DCHK = 4'd10;
	localparam logic [3:0] S_DWR  = 4'd11;

	logic [3:0] state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.mode > chse_pkg::MODE_DEL_LAST) begin
					cmd.fin    = 1'b1;
					cmd.fin_st = chse_pkg::ST_BAD;
					state_d    = S_IDLE;
				end else if (sts.mode <= chse_pkg::MODE_FIND) begin
					if (sts.bad_in) begin
						cmd.fin    = 1'b1;
						cmd.fin_st = chse_pkg::ST_BAD;
						state_d    = S_IDLE;
					end else if (sts.is_char) begin
						cmd.mul1 = 1'b1;
						state_d  = S_MUL2;
					end else begin
						state_d = S_DINI;
					end
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_DINI;
			end
			S_DINI: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_SCHK;
				end
			end
			S_SCHK: begin
				if (sts.idx_end) begin
					state_d = S_POST;
				end else begin
					cmd.rd_idx = 1'b1;
					state_d    = S_SCMP;
				end
			end
			S_SCMP: begin
				cmd.cmp = 1'b1;
				state_d = sts.match ? S_POST : S_SCHK;
			end
			S_POST: begin
				cmd.fin_bkt = 1'b1;
				cmd.fin     = 1'b1;
				state_d     = S_IDLE;
				if (sts.mode == chse_pkg::MODE_ADD) begin
					if (sts.hit) begin
						cmd.fin_st = chse_pkg::ST_DUP;
					end else if (sts.full) begin
						cmd.fin_st = chse_pkg::ST_FULL;
					end else begin
						cmd.add_tail = 1'b1;
						cmd.fin_st   = chse_pkg::ST_OK;
					end
				end else if (!sts.hit) begin
					cmd.fin_st = chse_pkg::ST_MISS;
				end else if (sts.mode == chse_pkg::MODE_DEL) begin
					cmd.fin = 1'b0;
					state_d = S_DCHK;
				end else begin
					cmd.fin_st = chse_pkg::ST_OK;
				end
			end
			S_SCAN: begin
				if (sts.scan_nz) begin
					if (sts.mode == chse_pkg::MODE_GET_FIRST ||
					    sts.mode == chse_pkg::MODE_GET_LAST) begin
						cmd.get_rd = 1'b1;
						state_d    = S_GWT;
					end else if (sts.mode == chse_pkg::MODE_DEL_FIRST) begin
						cmd.pos0 = 1'b1;
						state_d  = S_DCHK;
					end else begin
						cmd.dec     = 1'b1;
						cmd.fin     = 1'b1;
						cmd.fin_bkt = 1'b1;
						cmd.fin_st  = chse_pkg::ST_OK;
						state_d     = S_IDLE;
					end
				end else if (sts.scan_end) begin
					cmd.fin    = 1'b1;
					cmd.fin_st = chse_pkg::ST_MISS;
					state_d    = S_IDLE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_GWT: begin
				cmd.get_cap = 1'b1;
				cmd.fin     = 1'b1;
				cmd.fin_bkt = 1'b1;
				cmd.fin_st  = chse_pkg::ST_OK;
				state_d     = S_IDLE;
			end
			S_DCHK: begin
				if (sts.del_more) begin
					cmd.rd_next = 1'b1;
					state_d     = S_DWR;
				end else begin
					cmd.dec     = 1'b1;
					cmd.fin     = 1'b1;
					cmd.fin_bkt = 1'b1;
					cmd.fin_st  = chse_pkg::ST_OK;
					state_d     = S_IDLE;
				end
			end
			S_DWR: begin
				cmd.wr_shift = 1'b1;
				state_d      = S_DCHK;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/chse_dp.sv
// ----------------------------------------------------------------------------
// chse_dp
// Datapath: hash unit, serial modulo, chain counts, slot addressing, result.
// ----------------------------------------------------------------------------
module chse_dp #(
	parameter int NUM_BUCKETS = chse_pkg::NUM_BUCKETS_DEF,
	parameter int CHAIN_DEPTH = chse_pkg::CHAIN_DEPTH_DEF,
	parameter int AW = (NUM_BUCKETS * CHAIN_DEPTH > 1) ?
		$clog2(NUM_BUCKETS * CHAIN_DEPTH) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  chse_pkg::cmd_t cmd,
	output chse_pkg::sts_t sts,
	input  chse_pkg::req_t req,
	input  logic           hash_kind,
	input  logic [4:0]     bucket_count,
	output logic           ram_we,
	output logic [AW-1:0]  ram_waddr,
	output logic [31:0]    ram_wdata,
	output logic [AW-1:0]  ram_raddr,
	input  logic [31:0]    ram_rdata,
	output logic           done,
	output chse_pkg::rsp_t rsp
);

	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int IW = $clog2(CHAIN_DEPTH + 1);

	logic [2:0]    mode_q;
	logic [31:0]   key_q;
	logic [31:0]   tag_q;
	logic          hit_q;
	logic [20:0]   prod_q;
	logic [31:0]   quo_q;
	logic [4:0]    rem_q;
	logic [4:0]    dcnt_q;
	logic [BW-1:0] bkt_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] cnt_q [NUM_BUCKETS];
	logic          done_q;
	chse_pkg::rsp_t rsp_q;

	logic [4:0]    n_eff;
	logic [IW-1:0] cur_cnt;
	logic [5:0]    rem_t;
	logic [5:0]    nrem;
	logic [6:0]    c7;
	logic          c_ok;
	logic          last_op;
	logic [AW-1:0] base;
	logic [IW:0]   idx_p1;
	logic [IW-1:0] get_idx;

	always_comb begin
		if (bucket_count == 5'd0) begin
			n_eff = 5'd1;
		end else if ({27'd0, bucket_count} > NUM_BUCKETS) begin
			n_eff = 5'(NUM_BUCKETS);
		end else begin
			n_eff = bucket_count;
		end
	end

	assign cur_cnt = cnt_q[bkt_q];
	assign c7      = key_q[6:0];
	assign c_ok    = (key_q[7:0] != 8'd0) && !key_q[7];
	assign last_op = (mode_q == chse_pkg::MODE_GET_LAST) ||
	                 (mode_q == chse_pkg::MODE_DEL_LAST);
	assign rem_t   = {rem_q, quo_q[31]};
	assign nrem    = (rem_t >= {1'b0, n_eff}) ? (rem_t - {1'b0, n_eff}) : rem_t;
	assign base    = AW'(bkt_q) * AW'(CHAIN_DEPTH);
	assign idx_p1  = {1'b0, idx_q} + (IW + 1)'(1);
	assign get_idx = last_op ? (cur_cnt - IW'(1)) : IW'(0);

	assign sts.mode     = mode_q;
	assign sts.bad_in   = (tag_q == 32'd0) || (!hash_kind && key_q[31]);
	assign sts.is_char  = hash_kind;
	assign sts.div_last = (dcnt_q == 5'd31);
	assign sts.idx_end  = (idx_q == cur_cnt);
	assign sts.match    = (ram_rdata == tag_q);
	assign sts.hit      = hit_q;
	assign sts.full     = (cur_cnt == IW'(CHAIN_DEPTH));
	assign sts.scan_nz  = (cur_cnt != IW'(0));
	assign sts.scan_end = last_op ? (bkt_q == BW'(0)) :
	                      ({1'b0, 9'(bkt_q)} == {1'b0, 9'(n_eff) - 9'd1});
	assign sts.del_more = (idx_p1 < {1'b0, cur_cnt});

	assign ram_we    = cmd.add_tail | cmd.wr_shift;
	assign ram_waddr = cmd.add_tail ? (base + AW'(cur_cnt)) : (base + AW'(idx_q));
	assign ram_wdata = cmd.add_tail ? tag_q : ram_rdata;

	always_comb begin
		if (cmd.get_rd) begin
			ram_raddr = base + AW'(get_idx);
		end else if (cmd.rd_next) begin
			ram_raddr = base + AW'(idx_p1);
		end else begin
			ram_raddr = base + AW'(idx_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= req.mode;
			key_q  <= req.key;
			tag_q  <= req.value;
		end
		if (cmd.mul1) begin
			prod_q <= c_ok ? (21'(c7) * 21'(c7)) : 21'd0;
		end
		if (cmd.mul2) begin
			prod_q <= 21'(prod_q * (21'(c7) + 21'd1));
		end
		if (cmd.div_init) begin
			quo_q  <= hash_kind ? {12'd0, prod_q[20:1]} : key_q;
			rem_q  <= 5'd0;
			dcnt_q <= 5'd0;
		end
		if (cmd.div_step) begin
			quo_q  <= {quo_q[30:0], 1'b0};
			rem_q  <= nrem[4:0];
			dcnt_q <= dcnt_q + 5'd1;
			if (dcnt_q == 5'd31) begin
				bkt_q <= BW'(nrem);
				idx_q <= IW'(0);
			end
		end
		if (cmd.cmp && !sts.match) begin
			idx_q <= idx_q + IW'(1);
		end
		if (cmd.scan_init) begin
			bkt_q <= last_op ? BW'(n_eff - 5'd1) : BW'(0);
		end
		if (cmd.scan_step) begin
			bkt_q <= last_op ? (bkt_q - BW'(1)) : (bkt_q + BW'(1));
		end
		if (cmd.pos0) begin
			idx_q <= IW'(0);
		end
		if (cmd.wr_shift) begin
			idx_q <= idx_q + IW'(1);
		end
		if (cmd.fin) begin
			rsp_q.status      <= cmd.fin_st;
			rsp_q.found_value <= cmd.get_cap ? ram_rdata : 32'd0;
			rsp_q.bucket      <= cmd.fin_bkt ? 4'(bkt_q) : 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			done_q <= cmd.fin;
			if (cmd.load) begin
				hit_q <= 1'b0;
			end else if (cmd.cmp && sts.match) begin
				hit_q <= 1'b1;
			end
			if (cmd.add_tail) begin
				cnt_q[bkt_q] <= cur_cnt + IW'(1);
			end else if (cmd.dec) begin
				cnt_q[bkt_q] <= cur_cnt - IW'(1);
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### rtl/core/chse_chk.sv
// ----------------------------------------------------------------------------
// chse_chk
// Port-level checks on transaction sequencing and result encoding.
// ----------------------------------------------------------------------------
module chse_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input chse_pkg::rsp_t rsp
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status <= chse_pkg::ST_BAD))
		else $error("status code out of range");

	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == chse_pkg::ST_BAD) |->
			(rsp.bucket == 4'd0 && rsp.found_value == 32'd0))
		else $error("rejected transaction carries bucket or tag");

endmodule

bind chained_hash_set_engine chse_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

### tb/chained_hash_set_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_set_engine_tb
// Self-checking bench for the chained hash set engine. Commands go in through
// start/busy, one result per transaction is checked against a behavioral
// model of the bucket chains. Phases sweep hash kind and bucket count.
// ----------------------------------------------------------------------------
module chained_hash_set_engine_tb;
	import chse_pkg::*;

	localparam int NB = NUM_BUCKETS_DEF;
	localparam int CD = CHAIN_DEPTH_DEF;
	localparam int WDOG_LIMIT = 20000;

	class hash_set_scoreboard;
		logic [31:0] slots [NB][CD];
		int unsigned lens [NB];
		bit kind_char;
		int unsigned nbk_raw;
		rsp_t pending [$];
		int unsigned errors;

		function void clear();
			for (int i = 0; i < NB; i++) lens[i] = 0;
			kind_char = 0;
			nbk_raw = 16;
			pending.delete();
			errors = 0;
		endfunction

		function int unsigned active_buckets();
			int unsigned n;
			n = nbk_raw;
			if (n == 0) n = 1;
			if (n > NB) n = NB;
			return n;
		endfunction

		function void remove_slot(int unsigned b, int unsigned p);
			for (int unsigned i = p; i + 1 < lens[b]; i++) slots[b][i] = slots[b][i + 1];
			lens[b]--;
		endfunction

		function void note_command(req_t r);
			rsp_t e;
			int unsigned n, b, c;
			logic [63:0] s;
			int pos;
			bit ok, last;
			e = '{status: ST_BAD, found_value: '0, bucket: '0};
			n = active_buckets();
			if (r.mode == MODE_ADD || r.mode == MODE_DEL || r.mode == MODE_FIND) begin
				ok = (r.value != 0);
				if (kind_char) begin
					c = r.key[7:0];
					s = (c >= 1 && c <= 127) ? (64'(c) * c * (c + 1)) / 2 : 0;
					b = (s % n);
				end else begin
					if (r.key[31]) ok = 0;
					b = 32'(r.key) % n;
				end
				if (ok) begin
					e.bucket = b[3:0];
					pos = -1;
					for (int i = 0; i < lens[b]; i++)
						if (pos < 0 && slots[b][i] == r.value) pos = i;
					if (r.mode == MODE_ADD) begin
						if (pos >= 0) e.status = ST_DUP;
						else if (lens[b] >= CD) e.status = ST_FULL;
						else begin
							slots[b][lens[b]] = r.value;
							lens[b]++;
							e.status = ST_OK;
						end
					end else if (pos < 0) e.status = ST_MISS;
					else begin
						if (r.mode == MODE_DEL) remove_slot(b, pos);
						e.status = ST_OK;
					end
				end
			end else if (r.mode != 3'd7) begin
				last = (r.mode == MODE_GET_LAST || r.mode == MODE_DEL_LAST);
				e.status = ST_MISS;
				for (int unsigned i = 0; i < n; i++) begin
					b = last ? n - 1 - i : i;
					if (lens[b] != 0) begin
						e.status = ST_OK;
						e.bucket = b[3:0];
						if (r.mode == MODE_GET_FIRST || r.mode == MODE_GET_LAST)
							e.found_value = slots[b][last ? lens[b] - 1 : 0];
						else remove_slot(b, last ? lens[b] - 1 : 0);
						break;
					end
				end
			end
			pending.push_back(e);
		endfunction

		function void check_result(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", a);
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status || a.found_value !== e.found_value ||
					a.bucket !== e.bucket) begin
				errors++;
				if (errors <= 10) $display("mismatch: expected %p actual %p", e, a);
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done, psel, penable, pwrite, pready;
	req_t req;
	rsp_t rsp;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	hash_set_scoreboard sb;
	int unsigned idle_cycles;
	bit timed_out;
	logic [31:0] tag_pool [16];

	chained_hash_set_engine u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(rsp);
			if ((start && !busy) || done) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_HASH_KIND) sb.kind_char = val[0];
		else sb.nbk_raw = val[4:0];
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic issue(input logic [2:0] m, input logic [31:0] k, input logic [31:0] v);
		@(negedge clk);
		req <= '{mode: m, key: k, value: v};
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_command('{mode: m, key: k, value: v});
		@(negedge clk);
		start <= 0;
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_phase(input int unsigned count);
		logic [2:0] m;
		logic [31:0] k, v;
		int unsigned r;
		for (int unsigned i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40) m = MODE_ADD;
			else if (r < 55) m = MODE_DEL;
			else if (r < 70) m = MODE_FIND;
			else if (r < 98) m = 3'($urandom_range(3, 6));
			else m = 3'd7;
			r = $urandom_range(0, 9);
			k = (r < 7) ? $urandom_range(0, 40) : (r < 8 ? 32'($urandom_range(0, 255))
				: $urandom);
			r = $urandom_range(0, 19);
			v = (r < 17) ? tag_pool[$urandom_range(0, 15)] : (r < 18 ? 32'd0 : $urandom);
			issue(m, k, v);
		end
	endtask

	initial begin
		logic [31:0] bad_key;
		sb = new();
		sb.clear();
		idle_cycles = 0;
		arst_n = 0; start = 0; req = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		for (int i = 0; i < 16; i++) tag_pool[i] = (i < 2) ? {i[0], 31'h7fffffff} : $urandom;
		tag_pool[2] = 32'd1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		issue(MODE_GET_FIRST, 0, 0);
		issue(MODE_DEL_LAST, 0, 0);
		issue(MODE_ADD, 32'h7fffffff, 32'hffffffff);
		issue(MODE_ADD, 32'h7fffffff, 32'hffffffff);
		bad_key = 32'h80000000;
		issue(MODE_ADD, bad_key, 5);
		issue(MODE_ADD, 3, 0);
		for (int i = 1; i <= 9; i++) issue(MODE_ADD, 5, i);
		issue(MODE_FIND, 5, 4);
		issue(MODE_DEL, 5, 4);
		issue(MODE_FIND, 5, 4);
		issue(MODE_GET_FIRST, 0, 0);
		issue(MODE_GET_LAST, 0, 0);
		issue(MODE_DEL_FIRST, 0, 0);
		issue(MODE_DEL_LAST, 0, 0);
		issue(3'd7, 1, 1);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_HASH_KIND, ph[0] ? 32'hffffffff : 32'h0);
			case (ph)
				0: write_reg(REG_BUCKET_COUNT, 16);
				1: write_reg(REG_BUCKET_COUNT, 1);
				2: write_reg(REG_BUCKET_COUNT, 0);
				3: write_reg(REG_BUCKET_COUNT, 31);
				default: write_reg(REG_BUCKET_COUNT, $urandom);
			endcase
			if (ph == 1) begin
				issue(MODE_ADD, 32'hff, 7);
				issue(MODE_ADD, 32'h7f, 7);
				issue(MODE_ADD, 32'h80, 9);
			end
			random_phase(225);
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
